>>> design/sobs_pkg.sv
// Package for the set of bounded stacks.
// Holds the request and response transaction types and the kind and status codes.
// No dependencies.
package sobs_pkg;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_POP_AT = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADNUM = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
        logic [3:0]         stack_number;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [3:0]         stacks_in_use;
    } rsp_t;

endpackage

>>> design/set_of_bounded_stacks.sv
// Set of bounded stacks: response valid in the cycle after a request transaction is accepted.
// Throughput: one transaction per cycle; a held response stalls the request side.
// Entry memory: at most one write or one registered read per transaction.
// Reset: fill counts cleared, one substack in use, response register empty.
// Entry memory is not cleared; only entries below a fill count are ever read.
// Depends on sobs_pkg.
module set_of_bounded_stacks #(
    parameter int SUB_CAPACITY = 20,
    parameter int MAX_STACKS   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sobs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sobs_pkg::rsp_t rsp
);
    import sobs_pkg::*;

    localparam int DEPTH  = MAX_STACKS * SUB_CAPACITY;
    localparam int SIDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_STACKS + 1);
    localparam int FILL_W = $clog2(SUB_CAPACITY + 1);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W  = (CNT_W > 4) ? CNT_W : 4;

    logic [FILL_W-1:0]  fill_reg [MAX_STACKS];
    logic [FILL_W-1:0]  top_fill_reg, top_fill_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               out_valid_reg;
    logic [1:0]         status_reg, status_next;
    logic               take_ok_reg;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] mem [DEPTH];

    logic               accept;
    logic [SIDX_W-1:0]  top, sel, new_top;
    logic [FILL_W-1:0]  f_sel, fill_idx, new_fill;
    logic               wr, take, take_ok, fill_we;
    logic [NUM_W-1:0]   num_ext, total_ext;
    logic [AW-1:0]      addr;

    assign req_stall = out_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign num_ext   = NUM_W'(req.stack_number);
    assign total_ext = NUM_W'(total_reg);
    assign top       = SIDX_W'(total_reg - CNT_W'(1));

    always_comb
    begin
        sel         = top;
        status_next = ST_OK;
        wr          = 1'b0;
        take        = 1'b0;
        total_next  = total_reg;
        case (req.kind)
            KIND_PUSH:
            begin
                if (top_fill_reg >= FILL_W'(SUB_CAPACITY))
                begin
                    if (total_reg >= CNT_W'(MAX_STACKS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        sel        = SIDX_W'(total_reg);
                        total_next = CNT_W'(total_reg + CNT_W'(1));
                        wr         = 1'b1;
                    end
                end
                else
                begin
                    wr = 1'b1;
                end
            end
            KIND_POP:
            begin
                if (top_fill_reg == '0)
                begin
                    if (total_reg > CNT_W'(1))
                    begin
                        sel        = SIDX_W'(total_reg - CNT_W'(2));
                        total_next = CNT_W'(total_reg - CNT_W'(1));
                        take       = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                else
                begin
                    take = 1'b1;
                end
            end
            KIND_POP_AT:
            begin
                if (num_ext == '0 || num_ext > total_ext)
                begin
                    status_next = ST_BADNUM;
                end
                else
                begin
                    sel  = SIDX_W'(num_ext - NUM_W'(1));
                    take = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        f_sel   = fill_reg[sel];
        take_ok = take && (f_sel != '0);
        if (take && f_sel == '0)
        begin
            status_next = ST_EMPTY;
        end
        fill_idx = wr ? f_sel : FILL_W'(f_sel - FILL_W'(1));
        new_fill = wr ? FILL_W'(f_sel + FILL_W'(1)) : fill_idx;
        fill_we  = wr || take_ok;

        new_top       = SIDX_W'(total_next - CNT_W'(1));
        top_fill_next = top_fill_reg;
        if (sel == new_top && (fill_we || total_next != total_reg))
        begin
            top_fill_next = fill_we ? new_fill : f_sel;
        end

        addr = AW'(AW'(sel) * AW'(SUB_CAPACITY) + AW'(fill_idx));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
            top_fill_reg  <= '0;
            total_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            take_ok_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (fill_we)
                begin
                    fill_reg[sel] <= new_fill;
                end
                top_fill_reg  <= top_fill_next;
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                take_ok_reg   <= take_ok;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr)
        begin
            mem[addr] <= req.push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && take_ok)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp.pop_value     = take_ok_reg ? rd_data_reg : 32'sd0;
    assign rsp.status        = status_reg;
    assign rsp.stacks_in_use = 4'(total_reg);

endmodule

>>> design/sobs_checker.sv
// Port checker for set_of_bounded_stacks, bound to the top level.
// Depends on sobs_pkg and set_of_bounded_stacks.
module sobs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sobs_pkg::rsp_t rsp
);
    import sobs_pkg::*;

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted transaction gave no response");

    a_in_use_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.stacks_in_use != 4'd0))
        else $error("no substack in use");

    a_error_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.pop_value == 32'sd0))
        else $error("failed request returned a value");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind set_of_bounded_stacks sobs_checker u_sobs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
